// File: rtl/core/tch_pkg.sv
`default_nettype none
package tch_pkg;

    // CORDIC iteration count, capped at the arctangent table length
    localparam int CordicSteps = 16;
    localparam int AtanEntries = 24;
    localparam int NSteps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

    // Limit CORDIC gain in Q30
    localparam logic signed [32:0] GainQ30 = 33'sd652032874;

    // Tenths of a degree in a full turn
    localparam logic [11:0] DecidegFull = 12'd3600;

    // Arctangent of 2^-i in 32-bit binary angle units (pi = 2^31)
    localparam logic [31:0] AtanBam [AtanEntries] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Q30 sine/cosine with headroom
    typedef logic signed [32:0] t_trig;
    // Rotation-mode angle accumulator
    typedef logic signed [33:0] t_rang;
    // Horizontal components Xh, Yh
    typedef logic signed [48:0] t_horiz;
    // Vectoring-mode working values
    typedef logic signed [50:0] t_vec;

    // Raw magnetometer vector carried alongside the angles
    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
    } t_mag;

    // Sine and cosine of roll and pitch
    typedef struct packed {
        t_trig sr;
        t_trig cr;
        t_trig sp;
        t_trig cp;
    } t_trigset;

    // Configuration register indexes
    typedef enum logic {
        REG_DECL  = 1'b0,
        REG_MOUNT = 1'b1
    } t_reg_idx;

endpackage
`default_nettype wire

// File: rtl/core/tch_in_if.sv
`default_nettype none
interface tch_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;

    modport source (
        output valid, mag_x, mag_y, mag_z, roll_angle, pitch_angle,
        input  ready
    );
    modport sink (
        input  valid, mag_x, mag_y, mag_z, roll_angle, pitch_angle,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/tch_out_if.sv
`default_nettype none
interface tch_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] heading_decideg;

    modport source (
        output valid, heading_decideg,
        input  ready
    );
    modport sink (
        input  valid, heading_decideg,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/tilt_compensated_heading.sv
`default_nettype none
// Channel   Dir  Modport  Beat contents
// i_mag     in   sink     mag_x, mag_y, mag_z, roll_angle, pitch_angle
// o_head    out  source   heading_decideg
// i_cfg_*   in   -        write enable, register index, write data
//
// One beat enters per cycle while the output is not stalled; the two CORDIC
// pipelines are unrolled, one stage per iteration.
// Reset clears the valid bits and both offset registers.
// A stall at the output freezes every stage at once; nothing is lost or repeated.
module tilt_compensated_heading (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tch_in_if.sink           i_mag,
    tch_out_if.source        o_head,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data
);
    import tch_pkg::*;

    logic               s_ce;
    logic signed [11:0] r_decl;
    logic signed [9:0]  r_mount;

    t_mag     s_mag;
    logic     s_rot_v;
    t_trigset s_trig;
    t_mag     s_rot_mag;
    logic     s_tilt_v;
    t_horiz   s_xh, s_yh;
    logic     s_vec_v;
    logic [31:0] s_ang;

    logic [43:0]        r_p;
    logic [14:0]        r_u;
    logic [11:0]        r_head;
    logic [2:0]         r_v;

    logic signed [13:0] s_off;
    logic signed [14:0] s_t;
    logic signed [14:0] s_tr;
    logic [14:0]        s_h;

    // Whole pipeline advances unless the output beat is held
    assign s_ce        = !r_v[2] || o_head.ready;
    assign i_mag.ready = s_ce;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl  <= '0;
            r_mount <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DECL:  r_decl  <= i_cfg_data;
                REG_MOUNT: r_mount <= i_cfg_data[9:0];
                default:   ;
            endcase
        end
    end

    assign s_mag.mx = i_mag.mag_x;
    assign s_mag.my = i_mag.mag_y;
    assign s_mag.mz = i_mag.mag_z;

    tch_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (s_ce),
        .i_valid (i_mag.valid),
        .i_roll  (i_mag.roll_angle),
        .i_pitch (i_mag.pitch_angle),
        .i_mag   (s_mag),
        .o_valid (s_rot_v),
        .o_trig  (s_trig),
        .o_mag   (s_rot_mag)
    );

    tch_tilt u_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (s_ce),
        .i_valid (s_rot_v),
        .i_trig  (s_trig),
        .i_mag   (s_rot_mag),
        .o_valid (s_tilt_v),
        .o_xh    (s_xh),
        .o_yh    (s_yh)
    );

    tch_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (s_ce),
        .i_valid (s_tilt_v),
        .i_xh    (s_xh),
        .i_yh    (s_yh),
        .o_valid (s_vec_v),
        .o_ang   (s_ang)
    );

    // Scale the angle to tenths of a degree in Q32
    always_ff @(posedge i_clk) begin
        if (s_ce) begin
            r_p <= {12'b0, s_ang} * {32'b0, DecidegFull};
        end
    end

    // Add offsets, truncate toward zero, bias positive
    always_comb begin
        s_off = 14'(r_decl) + 14'(r_mount) * 14'sd10;
        s_t   = 15'(s_off) + $signed({3'b0, r_p[43:32]});
        s_tr  = s_t;
        if (s_t < 0 && r_p[31:0] != '0) begin
            s_tr = s_t + 15'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ce) begin
            r_u <= 15'(s_tr + 15'sd7200);
        end
    end

    // Wrap into a single turn
    always_comb begin
        if (r_u >= 15'd14400) begin
            s_h = r_u - 15'd14400;
        end else if (r_u >= 15'd10800) begin
            s_h = r_u - 15'd10800;
        end else if (r_u >= 15'd7200) begin
            s_h = r_u - 15'd7200;
        end else if (r_u >= 15'd3600) begin
            s_h = r_u - 15'd3600;
        end else begin
            s_h = r_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ce) begin
            r_head <= s_h[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (s_ce) begin
            r_v <= {r_v[1:0], s_vec_v};
        end
    end

    assign o_head.valid           = r_v[2];
    assign o_head.heading_decideg = r_head;

endmodule
`default_nettype wire

// File: rtl/core/tch_rot.sv
`default_nettype none
module tch_rot (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ce,
    input  wire logic              i_valid,
    input  wire logic signed [15:0] i_roll,
    input  wire logic signed [15:0] i_pitch,
    input  wire tch_pkg::t_mag     i_mag,
    output logic                   o_valid,
    output tch_pkg::t_trigset      o_trig,
    output tch_pkg::t_mag          o_mag
);
    import tch_pkg::*;

    // Lane 0 is roll, lane 1 is pitch
    t_trig            r_x    [2][NSteps+1];
    t_trig            r_y    [2][NSteps+1];
    t_rang            r_z    [2][NSteps+1];
    logic [1:0]       r_flip [NSteps+1];
    t_mag             r_mag  [NSteps+1];
    logic [NSteps:0]  r_v;
    logic             r_ov;
    t_trigset         r_trig;
    t_mag             r_omag;

    logic signed [15:0] s_ang [2];
    logic signed [15:0] s_red [2];
    logic [1:0]         s_flip;

    // Fold the angle into [-pi/2, pi/2]
    always_comb begin
        s_ang[0] = i_roll;
        s_ang[1] = i_pitch;
        for (int l = 0; l < 2; l++) begin
            if (s_ang[l] > 16'sd16384) begin
                s_red[l]  = s_ang[l] - 16'sd32767 - 16'sd1;
                s_flip[l] = 1'b1;
            end else if (s_ang[l] < -16'sd16384) begin
                s_red[l]  = s_ang[l] + 16'sd32767 + 16'sd1;
                s_flip[l] = 1'b1;
            end else begin
                s_red[l]  = s_ang[l];
                s_flip[l] = 1'b0;
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        // Load the first stage
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_x[l][0] <= GainQ30;
                r_y[l][0] <= '0;
                r_z[l][0] <= {{2{s_red[l][15]}}, s_red[l], 16'b0};
            end
        end

        // One rotation step per stage
        for (genvar i = 0; i < NSteps; i++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    if (r_z[l][i] >= 0) begin
                        r_x[l][i+1] <= r_x[l][i] - (r_y[l][i] >>> i);
                        r_y[l][i+1] <= r_y[l][i] + (r_x[l][i] >>> i);
                        r_z[l][i+1] <= r_z[l][i] - $signed({2'b0, AtanBam[i]});
                    end else begin
                        r_x[l][i+1] <= r_x[l][i] + (r_y[l][i] >>> i);
                        r_y[l][i+1] <= r_y[l][i] - (r_x[l][i] >>> i);
                        r_z[l][i+1] <= r_z[l][i] + $signed({2'b0, AtanBam[i]});
                    end
                end
            end
        end
    end

    // Carry the fold flags and the raw vector alongside
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_flip[0] <= s_flip;
            r_mag[0]  <= i_mag;
        end
    end

    for (genvar i = 0; i < NSteps; i++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_flip[i+1] <= r_flip[i];
                r_mag[i+1]  <= r_mag[i];
            end
        end
    end

    // Undo the fold and register the results
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_trig.sr <= r_flip[NSteps][0] ? -r_y[0][NSteps] : r_y[0][NSteps];
            r_trig.cr <= r_flip[NSteps][0] ? -r_x[0][NSteps] : r_x[0][NSteps];
            r_trig.sp <= r_flip[NSteps][1] ? -r_y[1][NSteps] : r_y[1][NSteps];
            r_trig.cp <= r_flip[NSteps][1] ? -r_x[1][NSteps] : r_x[1][NSteps];
            r_omag    <= r_mag[NSteps];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r_v  <= {r_v[NSteps-1:0], i_valid};
            r_ov <= r_v[NSteps];
        end
    end

    assign o_valid = r_ov;
    assign o_trig  = r_trig;
    assign o_mag   = r_omag;

endmodule
`default_nettype wire

// File: rtl/core/tch_tilt.sv
`default_nettype none
module tch_tilt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ce,
    input  wire logic              i_valid,
    input  wire tch_pkg::t_trigset i_trig,
    input  wire tch_pkg::t_mag     i_mag,
    output logic                   o_valid,
    output tch_pkg::t_horiz        o_xh,
    output tch_pkg::t_horiz        o_yh
);
    import tch_pkg::*;

    logic signed [65:0] s_m1;
    logic signed [65:0] s_m2;

    t_trig  r_q1, r_q2, r_cr, r_sr, r_cp;
    t_mag   r_mag;
    t_horiz r_a, r_b, r_c, r_d, r_e;
    t_horiz r_xh, r_yh;
    logic [2:0] r_v;

    assign s_m1 = 66'(i_trig.sr) * 66'(i_trig.sp);
    assign s_m2 = 66'(i_trig.sp) * 66'(i_trig.cr);

    // Cross terms back to Q30
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_q1  <= 33'(s_m1 >>> 30);
            r_q2  <= 33'(s_m2 >>> 30);
            r_cr  <= i_trig.cr;
            r_sr  <= i_trig.sr;
            r_cp  <= i_trig.cp;
            r_mag <= i_mag;
        end
    end

    // Scale the raw readings
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a <= 49'(r_mag.mx) * 49'(r_cp);
            r_b <= 49'(r_mag.my) * 49'(r_q1);
            r_c <= 49'(r_mag.mz) * 49'(r_q2);
            r_d <= 49'(r_mag.my) * 49'(r_cr);
            r_e <= 49'(r_mag.mz) * 49'(r_sr);
        end
    end

    // Sum into the horizontal plane
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xh <= r_a + r_b + r_c;
            r_yh <= r_d - r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_xh    = r_xh;
    assign o_yh    = r_yh;

endmodule
`default_nettype wire

// File: rtl/core/tch_vec.sv
`default_nettype none
module tch_vec (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_ce,
    input  wire logic            i_valid,
    input  wire tch_pkg::t_horiz i_xh,
    input  wire tch_pkg::t_horiz i_yh,
    output logic                 o_valid,
    output logic [31:0]          o_ang
);
    import tch_pkg::*;

    t_vec            r_x    [NSteps+1];
    t_vec            r_y    [NSteps+1];
    logic [31:0]     r_z    [NSteps+1];
    logic            r_zero [NSteps+1];
    logic [NSteps:0] r_v;
    logic            r_ov;
    logic [31:0]     r_ang;

    // Move the vector into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero[0] <= (i_xh == '0) && (i_yh == '0);
            if (i_xh < 0) begin
                r_x[0] <= -51'(i_xh);
                r_y[0] <= -51'(i_yh);
                r_z[0] <= 32'h80000000;
            end else begin
                r_x[0] <= 51'(i_xh);
                r_y[0] <= 51'(i_yh);
                r_z[0] <= '0;
            end
        end
    end

    // One vectoring step per stage
    for (genvar i = 0; i < NSteps; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + AtanBam[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - AtanBam[i];
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // A zero vector reads as angle zero
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ang <= r_zero[NSteps] ? '0 : r_z[NSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r_v  <= {r_v[NSteps-1:0], i_valid};
            r_ov <= r_v[NSteps];
        end
    end

    assign o_valid = r_ov;
    assign o_ang   = r_ang;

endmodule
`default_nettype wire
